// File: sv/dhsc_pkg.sv
package dhsc_pkg;

    localparam int MAX_LEN = 1024;
    localparam int IDX_W   = $clog2(MAX_LEN + 1);
    localparam int HASH_W  = 30;
    localparam int STEP_W  = $clog2(HASH_W);
    localparam int WORD_W  = 4 * HASH_W;

    localparam logic [HASH_W-1:0] MOD_A  = HASH_W'(1000000007);
    localparam logic [HASH_W-1:0] MOD_B  = HASH_W'(1000000009);
    localparam logic [HASH_W-1:0] BASE_A = HASH_W'(31);
    localparam logic [HASH_W-1:0] BASE_B = HASH_W'(37);
    localparam logic [6:0]        LETTER_BIAS = 7'd96;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_READ,
        ST_LD_POW_GO,
        ST_LD_POW_WAIT,
        ST_LD_HASH_GO,
        ST_LD_HASH_WAIT,
        ST_LD_WRITE,
        ST_Q_READ,
        ST_Q_POW,
        ST_W_READ_LO,
        ST_W_READ_HI,
        ST_W_GO,
        ST_W_WAIT,
        ST_W_CMP
    } state_t;

    typedef struct packed {
        logic                go;
        logic [HASH_W-1:0]   multiplicand;
        logic [HASH_W-1:0]   multiplier;
    } mul_cmd_t;

    typedef struct packed {
        logic                done;
        logic [HASH_W-1:0]   product;
    } mul_rsp_t;

endpackage

// File: sv/double_hash_substring_counter.sv
// Stores a lowercase string one letter per load transaction and answers
// substring-count queries with a pair of rolling hashes (base 31 modulo
// 1000000007 and base 37 modulo 1000000009). A load makes two passes
// through the bit-serial modular multipliers. A query with a bad range
// answers on the cycle after it is taken. A good query hashes the query
// window first; each window needs two reads of the hash memory and one
// modular multiply per modulus. busy stays high for the whole of a load
// or a good query, and does not rise for a bad range or a full string.
// A good query's result appears on the cycle that busy falls, with
// result_valid high for exactly one cycle; the receiver cannot stall it,
// so it must take the result in that cycle. Load transactions give no
// result. Letters past 1024 are dropped and set the sticky overflowed
// flag, which a load with start_new clears.
module double_hash_substring_counter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic        start_new,
    input  logic [6:0]  letter,
    input  logic [10:0] query_left,
    input  logic [10:0] query_right,
    output logic        result_valid,
    output logic [10:0] match_count,
    output logic        range_error,
    output logic        overflowed
);
    import dhsc_pkg::*;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  len_reg;
    logic              ovf_reg;
    logic [6:0]        letter_reg;
    logic [IDX_W-1:0]  lo_reg, hi_reg, qlen_reg;
    logic              target_reg;
    logic [HASH_W-1:0] pw_a_reg, pw_b_reg;
    logic [HASH_W-1:0] hlo_a_reg, hlo_b_reg;
    logic [HASH_W-1:0] hhi_a_reg, hhi_b_reg;
    logic [HASH_W-1:0] ta_reg, tb_reg;
    logic [10:0]       cnt_reg;
    logic              rv_reg, rerr_reg, rovf_reg;
    logic [10:0]       rcnt_reg;
    logic              rd_zero_reg;

    // Memory control and read data. Entry 0 is never stored; it reads as
    // hash zero and power one.
    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    logic [HASH_W-1:0] rd_ha, rd_hb, rd_pa, rd_pb;

    mul_cmd_t          cmd_a, cmd_b;
    mul_rsp_t          rsp_a, rsp_b;

    logic              accept;
    logic [IDX_W-1:0]  eff_len;
    logic              bad_range;
    logic [IDX_W-1:0]  q_len;
    logic [HASH_W-1:0] va, vb, new_ha, new_hb;
    logic [HASH_W:0]   sum_a, sum_b;
    logic [HASH_W-1:0] win_a, win_b;

    dhsc_ram #(.WIDTH(WORD_W), .DEPTH(MAX_LEN + 1)) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    dhsc_modmul u_mul_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (MOD_A),
        .cmd     (cmd_a),
        .rsp     (rsp_a)
    );

    dhsc_modmul u_mul_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (MOD_B),
        .cmd     (cmd_b),
        .rsp     (rsp_b)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign rd_ha = rd_zero_reg ? '0 : ram_rdata[4*HASH_W-1:3*HASH_W];
    assign rd_hb = rd_zero_reg ? '0 : ram_rdata[3*HASH_W-1:2*HASH_W];
    assign rd_pa = rd_zero_reg ? HASH_W'(1) : ram_rdata[2*HASH_W-1:HASH_W];
    assign rd_pb = rd_zero_reg ? HASH_W'(1) : ram_rdata[HASH_W-1:0];

    // A new string starts empty; the length check uses the cleared length.
    assign eff_len   = start_new ? '0 : len_reg;
    assign bad_range = (query_left == '0) || (query_right < query_left)
                       || (query_right > len_reg);
    assign q_len     = IDX_W'(query_right - query_left + 1'b1);

    // Letter value is (letter - 96), folded into the field when negative.
    always_comb
    begin
        if (letter_reg >= LETTER_BIAS)
        begin
            va = HASH_W'(letter_reg - LETTER_BIAS);
            vb = HASH_W'(letter_reg - LETTER_BIAS);
        end
        else
        begin
            va = MOD_A - HASH_W'(LETTER_BIAS - letter_reg);
            vb = MOD_B - HASH_W'(LETTER_BIAS - letter_reg);
        end
        sum_a  = {1'b0, rsp_a.product} + {1'b0, va};
        sum_b  = {1'b0, rsp_b.product} + {1'b0, vb};
        new_ha = (sum_a >= {1'b0, MOD_A}) ? HASH_W'(sum_a - {1'b0, MOD_A})
                                          : sum_a[HASH_W-1:0];
        new_hb = (sum_b >= {1'b0, MOD_B}) ? HASH_W'(sum_b - {1'b0, MOD_B})
                                          : sum_b[HASH_W-1:0];
    end

    // Window hash: h[hi] - h[lo] * power[len], modulo each prime.
    always_comb
    begin
        win_a = (hhi_a_reg >= rsp_a.product) ? HASH_W'(hhi_a_reg - rsp_a.product)
                                             : HASH_W'(hhi_a_reg + MOD_A - rsp_a.product);
        win_b = (hhi_b_reg >= rsp_b.product) ? HASH_W'(hhi_b_reg - rsp_b.product)
                                             : HASH_W'(hhi_b_reg + MOD_B - rsp_b.product);
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_LOAD)
                    begin
                        if (eff_len < IDX_W'(MAX_LEN))
                        begin
                            state_next = ST_LD_READ;
                        end
                    end
                    else if (!bad_range)
                    begin
                        state_next = ST_Q_READ;
                    end
                end
            end
            ST_LD_READ:      state_next = ST_LD_POW_GO;
            ST_LD_POW_GO:    state_next = ST_LD_POW_WAIT;
            ST_LD_POW_WAIT:  state_next = rsp_a.done ? ST_LD_HASH_GO : ST_LD_POW_WAIT;
            ST_LD_HASH_GO:   state_next = ST_LD_HASH_WAIT;
            ST_LD_HASH_WAIT: state_next = rsp_a.done ? ST_LD_WRITE : ST_LD_HASH_WAIT;
            ST_LD_WRITE:     state_next = ST_IDLE;
            ST_Q_READ:       state_next = ST_Q_POW;
            ST_Q_POW:        state_next = ST_W_READ_LO;
            ST_W_READ_LO:    state_next = ST_W_READ_HI;
            ST_W_READ_HI:    state_next = ST_W_GO;
            ST_W_GO:         state_next = ST_W_WAIT;
            ST_W_WAIT:       state_next = rsp_a.done ? ST_W_CMP : ST_W_WAIT;
            ST_W_CMP:
            begin
                if (!target_reg && (hi_reg == len_reg))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_W_READ_LO;
                end
            end
            default:         state_next = ST_IDLE;
        endcase
    end

    // Memory and multiplier control.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = IDX_W'(len_reg + 1'b1);
        ram_wdata = {new_ha, new_hb, pw_a_reg, pw_b_reg};
        ram_re    = 1'b0;
        ram_raddr = len_reg;
        cmd_a     = '0;
        cmd_b     = '0;
        unique case (state_reg)
            ST_LD_READ:
            begin
                ram_re = 1'b1;
            end
            ST_LD_POW_GO:
            begin
                cmd_a = '{go: 1'b1, multiplicand: rd_pa, multiplier: BASE_A};
                cmd_b = '{go: 1'b1, multiplicand: rd_pb, multiplier: BASE_B};
            end
            ST_LD_HASH_GO:
            begin
                cmd_a = '{go: 1'b1, multiplicand: hlo_a_reg, multiplier: BASE_A};
                cmd_b = '{go: 1'b1, multiplicand: hlo_b_reg, multiplier: BASE_B};
            end
            ST_LD_WRITE:
            begin
                ram_we = 1'b1;
            end
            ST_Q_READ:
            begin
                ram_re    = 1'b1;
                ram_raddr = qlen_reg;
            end
            ST_W_READ_LO:
            begin
                ram_re    = 1'b1;
                ram_raddr = lo_reg;
            end
            ST_W_READ_HI:
            begin
                ram_re    = 1'b1;
                ram_raddr = hi_reg;
            end
            ST_W_GO:
            begin
                cmd_a = '{go: 1'b1, multiplicand: hlo_a_reg, multiplier: pw_a_reg};
                cmd_b = '{go: 1'b1, multiplicand: hlo_b_reg, multiplier: pw_b_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            rv_reg      <= 1'b0;
            rd_zero_reg <= 1'b0;
            target_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= 1'b0;
            if (ram_re)
            begin
                rd_zero_reg <= (ram_raddr == '0);
            end
            if (accept)
            begin
                if (req_type == REQ_LOAD)
                begin
                    len_reg <= eff_len;
                    if (eff_len >= IDX_W'(MAX_LEN))
                    begin
                        ovf_reg <= 1'b1;
                    end
                    else if (start_new)
                    begin
                        ovf_reg <= 1'b0;
                    end
                end
                else if (bad_range)
                begin
                    rv_reg <= 1'b1;
                end
                else
                begin
                    target_reg <= 1'b1;
                end
            end
            if (state_reg == ST_LD_WRITE)
            begin
                len_reg <= IDX_W'(len_reg + 1'b1);
            end
            if (state_reg == ST_W_CMP)
            begin
                target_reg <= 1'b0;
                if (!target_reg && (hi_reg == len_reg))
                begin
                    rv_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            letter_reg <= letter;
            lo_reg     <= IDX_W'(query_left - 1'b1);
            hi_reg     <= query_right;
            qlen_reg   <= q_len;
            rcnt_reg   <= '0;
            rerr_reg   <= bad_range;
            rovf_reg   <= ovf_reg;
        end
        unique case (state_reg)
            ST_LD_POW_GO:
            begin
                hlo_a_reg <= rd_ha;
                hlo_b_reg <= rd_hb;
            end
            ST_LD_POW_WAIT:
            begin
                if (rsp_a.done)
                begin
                    pw_a_reg <= rsp_a.product;
                    pw_b_reg <= rsp_b.product;
                end
            end
            ST_Q_POW:
            begin
                pw_a_reg <= rd_pa;
                pw_b_reg <= rd_pb;
            end
            ST_W_READ_HI:
            begin
                hlo_a_reg <= rd_ha;
                hlo_b_reg <= rd_hb;
            end
            ST_W_GO:
            begin
                hhi_a_reg <= rd_ha;
                hhi_b_reg <= rd_hb;
            end
            ST_W_CMP:
            begin
                if (target_reg)
                begin
                    // The query window's hash is the target; now scan from the start.
                    ta_reg  <= win_a;
                    tb_reg  <= win_b;
                    cnt_reg <= '0;
                    lo_reg  <= '0;
                    hi_reg  <= qlen_reg;
                end
                else
                begin
                    if ((win_a == ta_reg) && (win_b == tb_reg))
                    begin
                        cnt_reg  <= cnt_reg + 1'b1;
                        rcnt_reg <= cnt_reg + 1'b1;
                    end
                    else
                    begin
                        rcnt_reg <= cnt_reg;
                    end
                    lo_reg <= IDX_W'(lo_reg + 1'b1);
                    hi_reg <= IDX_W'(hi_reg + 1'b1);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result_valid = rv_reg;
    assign match_count  = rcnt_reg;
    assign range_error  = rerr_reg;
    assign overflowed   = rovf_reg;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= IDX_W'(MAX_LEN))
        else $error("stored length beyond capacity");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && range_error) |-> (match_count == '0))
        else $error("range error with nonzero count");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($past(state_reg) == ST_IDLE || $past(state_reg) == ST_W_CMP))
        else $error("result from unexpected state");

    a_lanes_sync: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_a.done == rsp_b.done)
        else $error("multiplier lanes out of step");
`endif

endmodule

// File: sv/dhsc_ram.sv
module dhsc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/dhsc_modmul.sv
module dhsc_modmul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [dhsc_pkg::HASH_W-1:0] modulus,
    input  dhsc_pkg::mul_cmd_t        cmd,
    output dhsc_pkg::mul_rsp_t        rsp
);
    import dhsc_pkg::*;

    // Shift-and-add modular multiply, one multiplier bit per cycle, MSB first.
    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [HASH_W-1:0] acc_reg;
    logic [HASH_W-1:0] a_reg;
    logic [HASH_W-1:0] b_reg;
    logic [HASH_W:0]   dbl;
    logic [HASH_W-1:0] dbl_red;
    logic [HASH_W:0]   sum;
    logic [HASH_W-1:0] acc_next;

    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, modulus}) ? HASH_W'(dbl - {1'b0, modulus})
                                           : dbl[HASH_W-1:0];
        sum     = {1'b0, dbl_red} + (b_reg[HASH_W-1] ? {1'b0, a_reg} : '0);
        acc_next = (sum >= {1'b0, modulus}) ? HASH_W'(sum - {1'b0, modulus})
                                            : sum[HASH_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.go)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(HASH_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.go)
        begin
            acc_reg <= '0;
            a_reg   <= cmd.multiplicand;
            b_reg   <= cmd.multiplier;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[HASH_W-2:0], 1'b0};
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule
